[hdl/lkvc_pkg.sv]
// Shared types and constants for the LRU key/value cache.
// No dependencies; imported by every module of the block.
package lkvc_pkg;

	localparam int ENTRIES  = 16;
	localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int RANK_W   = IDX_W;
	localparam int CNT_W    = $clog2(ENTRIES + 1);
	localparam int KEY_W    = 32;
	localparam int VAL_W    = 32;
	localparam int CAP_W    = 5;
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;
	localparam int QDEPTH   = 2;
	localparam int QPTR_W   = 1;
	localparam int QCNT_W   = 2;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	// register indexes (word address paddr[2])
	localparam logic REG_CAPACITY = 1'b0;

	// operation codes
	localparam logic CMD_GET = 1'b0;
	localparam logic CMD_PUT = 1'b1;

	typedef struct packed {
		logic                    is_put;
		logic signed [KEY_W-1:0] key;
		logic signed [VAL_W-1:0] value;
	} req_t;

endpackage

[hdl/lkvc_front.sv]
// Front end: accepts items, classifies the operation and queues them.
// Depends on lkvc_pkg; feeds lkvc_back through a two-entry queue.
module lkvc_front import lkvc_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    cmd,
	input  logic signed [KEY_W-1:0] key,
	input  logic signed [VAL_W-1:0] value,
	output logic                    req_valid,
	output req_t                    req,
	input  logic                    req_pop
);

	req_t              ent_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              push;
	logic              pop;
	req_t              new_req;

	assign in_ready  = (cnt_q != QCNT_W'(QDEPTH));
	assign req_valid = (cnt_q != '0);
	assign req       = ent_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = req_pop && req_valid;

	always_comb begin
		new_req.is_put = (cmd == CMD_PUT);
		new_req.key    = key;
		new_req.value  = value;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) ent_q[wr_ptr_q] <= new_req;
	end

endmodule

[hdl/lkvc_back.sv]
// Back end: the entry store with parallel key compare and recency ranks,
// plus the result register. Depends on lkvc_pkg; driven by lkvc_front.
module lkvc_back import lkvc_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    clear,
	input  logic [CAP_W-1:0]        capacity,
	input  logic                    req_valid,
	input  req_t                    req,
	output logic                    req_pop,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    hit,
	output logic signed [VAL_W-1:0] read_value
);

	logic                    valid_q [ENTRIES];
	logic signed [KEY_W-1:0] key_q   [ENTRIES];
	logic signed [VAL_W-1:0] val_q   [ENTRIES];
	logic [RANK_W-1:0]       rank_q  [ENTRIES];
	logic [CNT_W-1:0]        live_q;

	logic                    out_vld_q;
	logic                    hit_q;
	logic signed [VAL_W-1:0] rdata_q;

	logic              go;
	logic              any_hit;
	logic [IDX_W-1:0]  hit_idx;
	logic [RANK_W-1:0] hit_rank;
	logic [CNT_W-1:0]  eff_cap;
	logic              evict;
	logic [RANK_W-1:0] oldest;
	logic [IDX_W-1:0]  victim_idx;
	logic [IDX_W-1:0]  free_idx;
	logic [IDX_W-1:0]  slot;

	assign out_valid  = out_vld_q;
	assign hit        = hit_q;
	assign read_value = rdata_q;

	// a put never waits on the result register
	assign go      = req_valid && (req.is_put || !out_vld_q || out_ready);
	assign req_pop = go;

	always_comb begin
		if (capacity == '0)
			eff_cap = CNT_W'(1);
		else if (CNT_W'(capacity) > CNT_W'(ENTRIES))
			eff_cap = CNT_W'(ENTRIES);
		else
			eff_cap = CNT_W'(capacity);
	end

	assign evict  = (live_q >= eff_cap) && (live_q != '0);
	assign oldest = RANK_W'(live_q - 1'b1);

	// keys are unique and ranks distinct, so matches are one-hot
	always_comb begin
		any_hit    = 1'b0;
		hit_idx    = '0;
		victim_idx = '0;
		free_idx   = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (valid_q[i] && key_q[i] == req.key) begin
				any_hit = 1'b1;
				hit_idx = hit_idx | IDX_W'(i);
			end
			if (valid_q[i] && rank_q[i] == oldest)
				victim_idx = victim_idx | IDX_W'(i);
		end
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (!valid_q[i]) free_idx = IDX_W'(i);
		end
	end

	assign hit_rank = rank_q[hit_idx];
	assign slot     = evict ? victim_idx : free_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) valid_q[i] <= 1'b0;
			live_q <= '0;
		end else if (clear) begin
			for (int i = 0; i < ENTRIES; i++) valid_q[i] <= 1'b0;
			live_q <= '0;
		end else if (go && req.is_put && !any_hit) begin
			valid_q[slot] <= 1'b1;
			if (!evict) live_q <= live_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			if (any_hit) begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (valid_q[i] && rank_q[i] < hit_rank)
						rank_q[i] <= rank_q[i] + 1'b1;
				end
				rank_q[hit_idx] <= '0;
				if (req.is_put) val_q[hit_idx] <= req.value;
			end else if (req.is_put) begin
				// age every survivor, then place the new item as most recent
				for (int i = 0; i < ENTRIES; i++) begin
					if (valid_q[i] && !(evict && IDX_W'(i) == victim_idx))
						rank_q[i] <= rank_q[i] + 1'b1;
				end
				rank_q[slot] <= '0;
				key_q[slot]  <= req.key;
				val_q[slot]  <= req.value;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (go && !req.is_put) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && !req.is_put) begin
			hit_q   <= any_hit;
			rdata_q <= any_hit ? val_q[hit_idx] : '0;
		end
	end

endmodule

[hdl/lru_key_value_cache_unit.sv]
// Top level of the LRU key/value cache: APB capacity register, front queue
// and back-end store. Depends on lkvc_pkg, lkvc_front and lkvc_back.
//
//   channel | signals                                | direction
//   in      | in_valid, in_ready, cmd, key, value    | request items
//   out     | out_valid, out_ready, hit, read_value  | get results
//   cfg     | psel, penable, pwrite, paddr, pwdata,  | capacity register
//           | prdata, pready                         |
//
// The front accepts one item per cycle into a two-entry queue while the queue
// is not full; the back end executes the queue head, and a get result is then
// registered in the output register. The queue never
// fills while results are taken, so items may follow back to back.
// Reset empties the store and sets capacity to 16; a capacity write empties it.
// A held result stalls a get at the queue head only; a put at the head still executes.
module lru_key_value_cache_unit import lkvc_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    cmd,
	input  logic signed [KEY_W-1:0] key,
	input  logic signed [VAL_W-1:0] value,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    hit,
	output logic signed [VAL_W-1:0] read_value,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [PADDR_W-1:0]      paddr,
	input  logic [PDATA_W-1:0]      pwdata,
	output logic [PDATA_W-1:0]      prdata,
	output logic                    pready
);

	logic [CAP_W-1:0] cap_q;
	logic             cap_wr;
	logic             req_valid;
	logic             req_pop;
	req_t             req;

	assign pready = 1'b1;
	assign cap_wr = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);
	assign prdata = (paddr[2] == REG_CAPACITY) ? PDATA_W'(cap_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cap_wr) begin
			cap_q <= pwdata[CAP_W-1:0];
		end
	end

	lkvc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.key       (key),
		.value     (value),
		.req_valid (req_valid),
		.req       (req),
		.req_pop   (req_pop)
	);

	lkvc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.clear      (cap_wr),
		.capacity   (cap_q),
		.req_valid  (req_valid),
		.req        (req),
		.req_pop    (req_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.hit        (hit),
		.read_value (read_value)
	);

endmodule

[hdl/lkvc_checker.sv]
// Port-level checks for the LRU key/value cache, bound to the top level.
// Depends on lkvc_pkg and lru_key_value_cache_unit.
module lkvc_checker import lkvc_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic                    hit,
	input logic signed [VAL_W-1:0] read_value,
	input logic                    psel,
	input logic                    penable,
	input logic                    pwrite,
	input logic [PADDR_W-1:0]      paddr,
	input logic [PDATA_W-1:0]      pwdata,
	input logic [PDATA_W-1:0]      prdata,
	input logic                    pready
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(read_value))
		else $error("result changed while stalled");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> read_value == '0)
		else $error("miss result carries a nonzero value");

	a_cap_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready && paddr[2] == REG_CAPACITY
		|=> paddr[2] != REG_CAPACITY || prdata == PDATA_W'($past(pwdata[CAP_W-1:0])))
		else $error("capacity readback differs from the written value");

	a_prdata_upper: assert property (@(posedge clk) disable iff (!arst_n)
		prdata[PDATA_W-1:CAP_W] == '0)
		else $error("unused register bits read nonzero");

endmodule

bind lru_key_value_cache_unit lkvc_checker u_lkvc_checker (.*);
